>>> rtl/core/tlbc_pkg.sv
package tlbc_pkg;

    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned SecsWidth   = 8;
    localparam int unsigned OpWidth     = 2;
    localparam int unsigned MsPerSecond = 1000;
    localparam int unsigned OffsetWidth = $clog2(((1 << SecsWidth) - 1) * MsPerSecond + 1);

    typedef logic [OpWidth-1:0]     opcode_t;
    typedef logic [TimeWidth-1:0]   time_t;
    typedef logic [SecsWidth-1:0]   secs_t;
    typedef logic [OffsetWidth-1:0] offset_t;

    localparam opcode_t OP_UPDATE = 2'd0;
    localparam opcode_t OP_START  = 2'd1;
    localparam opcode_t OP_STOP   = 2'd2;

    localparam time_t DEADLINE_NEVER = '1;
    localparam time_t DEADLINE_NONE  = '0;

    typedef struct packed {
        opcode_t opcode;
        time_t   now_ms;
        secs_t   blink_seconds;
        time_t   toggle_period_ms;
    } cmd_t;

    typedef struct packed {
        logic led_lit;
        logic is_blinking;
    } status_t;

    // registered request handed to the core
    typedef struct packed {
        logic    valid;
        opcode_t opcode;
        time_t   now_ms;
        offset_t offset_ms;
        logic    secs_zero;
        time_t   period_ms;
    } stage_t;

endpackage

>>> rtl/core/tlbc_cmd_if.sv
interface tlbc_cmd_if;
    import tlbc_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tlbc_status_if.sv
interface tlbc_status_if;
    import tlbc_pkg::*;

    logic    valid;
    logic    ready;
    status_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tlbc_in_stage.sv
module tlbc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    tlbc_cmd_if.sink        cmd,
    input  logic            advance,
    output tlbc_pkg::stage_t stage
);
    import tlbc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    stage_t  data_reg;
    stage_t  data_next;
    logic    take;

    assign cmd.ready = !valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.ready)
        begin
            valid_next = cmd.valid;
        end
    end

    always_comb
    begin
        data_next           = data_reg;
        data_next.valid     = 1'b0;
        if (take)
        begin
            data_next.opcode    = cmd.data.opcode;
            data_next.now_ms    = cmd.data.now_ms;
            data_next.offset_ms = OffsetWidth'(cmd.data.blink_seconds * MsPerSecond);
            data_next.secs_zero = (cmd.data.blink_seconds == '0);
            data_next.period_ms = cmd.data.toggle_period_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end
endmodule

>>> rtl/core/tlbc_core.sv
module tlbc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             led_rest_on,
    input  tlbc_pkg::stage_t stage,
    output logic             advance,
    tlbc_status_if.source    status
);
    import tlbc_pkg::*;

    time_t   last_toggle_reg;
    time_t   last_toggle_next;
    time_t   deadline_reg;
    time_t   deadline_next;
    time_t   period_reg;
    time_t   period_next;
    logic    led_reg;
    logic    led_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t out_data_reg;
    status_t out_data_next;

    time_t   deadline_sum;
    time_t   elapsed;
    logic    fire;

    assign advance      = !out_valid_reg || status.ready;
    assign fire         = stage.valid && advance;
    assign deadline_sum = stage.now_ms + TimeWidth'(stage.offset_ms);
    assign elapsed      = stage.now_ms - last_toggle_reg;

    always_comb
    begin
        last_toggle_next = last_toggle_reg;
        deadline_next    = deadline_reg;
        period_next      = period_reg;
        led_next         = led_reg;
        case (stage.opcode)
            OP_UPDATE:
            begin
                if (stage.now_ms > deadline_reg)
                begin
                    deadline_next = DEADLINE_NONE;
                    led_next      = led_rest_on;
                end
                else if (deadline_reg != DEADLINE_NONE && stage.now_ms >= last_toggle_reg
                         && elapsed >= period_reg)
                begin
                    last_toggle_next = stage.now_ms;
                    led_next         = !led_reg;
                end
            end
            OP_START:
            begin
                if (deadline_reg == DEADLINE_NONE)
                begin
                    last_toggle_next = stage.now_ms;
                    period_next      = stage.period_ms;
                    deadline_next    = stage.secs_zero ? DEADLINE_NEVER : deadline_sum;
                    led_next         = !led_reg;
                end
            end
            OP_STOP:
            begin
                deadline_next = DEADLINE_NONE;
                led_next      = led_rest_on;
            end
            default:
            begin
                led_next = led_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = stage.valid;
        end
        if (fire)
        begin
            out_data_next.led_lit     = led_next;
            out_data_next.is_blinking = (deadline_next != DEADLINE_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_toggle_reg <= '0;
            deadline_reg    <= DEADLINE_NONE;
            period_reg      <= '0;
            led_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                last_toggle_reg <= last_toggle_next;
                deadline_reg    <= deadline_next;
                period_reg      <= period_next;
                led_reg         <= led_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;
endmodule

>>> rtl/core/timed_led_blink_controller_unit.sv
// A request passes the input register, then the result register, before its status is
// valid; status back-pressure stalls both. Throughput: one request per cycle when not
// stalled; the blink state updates as each request leaves the input register, so
// back-to-back requests see each other's effect.
// Reset (async, rst_n low): not blinking, LED dark, times and period zero, rest level dark,
// both pipeline stages empty.
module timed_led_blink_controller_unit (
    input  logic          clk,
    input  logic          rst_n,
    tlbc_cmd_if.sink      cmd,
    tlbc_status_if.source status,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import tlbc_pkg::*;

    stage_t stage;
    logic   advance;
    logic   rest_on_reg;
    logic   rest_on_next;

    assign rest_on_next = cfg_we ? cfg_wdata : rest_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_on_reg <= 1'b0;
        end
        else
        begin
            rest_on_reg <= rest_on_next;
        end
    end

    tlbc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .stage   (stage)
    );

    tlbc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .led_rest_on (rest_on_reg),
        .stage       (stage),
        .advance     (advance),
        .status      (status)
    );
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tlbc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    tlbc_cmd_if    cmd_bus ();
    tlbc_status_if status_bus ();

    timed_led_blink_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .status    (status_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    time_t   sim_last_toggle;
    time_t   sim_deadline;
    time_t   sim_period;
    logic    sim_led;
    logic    sim_rest_on;

    status_t expected_status [$];
    int      mismatch_count;
    int      items_sent;
    int      stall_cycles;
    int      hold_request;
    bit      burst_mode;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_gap();
        if (burst_mode)
            return 0;
        return int'($urandom_range(0, 12));
    endfunction

    task automatic predict_status(input cmd_t c);
        status_t s;
        case (c.opcode)
            OP_UPDATE:
            begin
                if (c.now_ms > sim_deadline)
                begin
                    sim_deadline = DEADLINE_NONE;
                    sim_led      = sim_rest_on;
                end
                else if (sim_deadline != DEADLINE_NONE && c.now_ms >= sim_last_toggle &&
                         (c.now_ms - sim_last_toggle) >= sim_period)
                begin
                    sim_last_toggle = c.now_ms;
                    sim_led         = ~sim_led;
                end
            end
            OP_START:
            begin
                if (sim_deadline == DEADLINE_NONE)
                begin
                    sim_last_toggle = c.now_ms;
                    sim_period      = c.toggle_period_ms;
                    if (c.blink_seconds == '0)
                        sim_deadline = DEADLINE_NEVER;
                    else
                        sim_deadline = c.now_ms +
                                       time_t'(c.blink_seconds) * time_t'(MsPerSecond);
                    sim_led = ~sim_led;
                end
            end
            OP_STOP:
            begin
                sim_deadline = DEADLINE_NONE;
                sim_led      = sim_rest_on;
            end
            default:
            begin
            end
        endcase
        s.led_lit     = sim_led;
        s.is_blinking = (sim_deadline != DEADLINE_NONE);
        expected_status.push_back(s);
    endtask

    task automatic send_cmd(input opcode_t op, input time_t now, input secs_t secs,
                            input time_t period);
        int   gap;
        cmd_t c;
        gap                = draw_gap();
        c.opcode           = op;
        c.now_ms           = now;
        c.blink_seconds    = secs;
        c.toggle_period_ms = period;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= c;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        predict_status(c);
        items_sent++;
    endtask

    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rest_level(input logic level);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(posedge clk);
        cfg_we      <= 1'b0;
        sim_rest_on = level;
    endtask

    task automatic test_directed_cases();
        time_t near_wrap;
        near_wrap = time_t'(0) - time_t'(255 * MsPerSecond);
        write_rest_level(1'b0);
        send_cmd(OP_UPDATE, 32'd0, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, 32'd5, 8'd0, 32'd0);
        send_cmd(OP_START, 32'd1000, 8'd2, 32'd100);
        send_cmd(OP_UPDATE, 32'd1050, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, 32'd1100, 8'd0, 32'd0);
        send_cmd(OP_START, 32'd1200, 8'd9, 32'd7);
        send_cmd(opcode_t'(3), '1, '1, '1);
        send_cmd(OP_UPDATE, 32'd1000, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, 32'd3000, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, 32'd3001, 8'd0, 32'd0);
        // never-expiring blink, zero period
        send_cmd(OP_START, 32'd10, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, 32'd10, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, '1, '1, '1);
        send_cmd(OP_STOP, 32'd0, 8'd0, 32'd0);
        send_cmd(OP_STOP, '1, '1, '1);
        // deadline sum wraps to exactly zero
        send_cmd(OP_START, near_wrap, 8'd255, '1);
        send_cmd(OP_UPDATE, near_wrap + 32'd1, 8'd0, 32'd0);
        // deadline wraps past zero, time then wraps below last toggle
        send_cmd(OP_START, '1, 8'd255, 32'd5);
        send_cmd(OP_UPDATE, 32'd0, 8'd0, 32'd0);
        send_cmd(OP_UPDATE, time_t'(255 * MsPerSecond), 8'd0, 32'd0);
        send_cmd(OP_STOP, 32'd0, 8'd0, 32'd0);
    endtask

    task automatic test_rest_level();
        write_rest_level(1'b1);
        send_cmd(OP_STOP, 32'd0, 8'd0, 32'd0);
        send_cmd(OP_START, 32'd50, 8'd1, 32'd10);
        send_cmd(OP_UPDATE, 32'd1051, 8'd0, 32'd0);
        send_cmd(OP_START, 32'd2000, 8'd0, 32'd20);
        write_rest_level(1'b0);
        send_cmd(OP_UPDATE, 32'd2020, 8'd0, 32'd0);
        send_cmd(OP_STOP, 32'd2021, 8'd0, 32'd0);
    endtask

    task automatic test_input_stall();
        wait_idle();
        burst_mode   = 1'b1;
        hold_request = HOLD_CYCLES;
        send_cmd(OP_START, $urandom, 8'd0, $urandom_range(0, 50));
        repeat (40)
            send_cmd(OP_UPDATE, $urandom_range(0, 5000), secs_t'($urandom), $urandom);
        burst_mode = 1'b0;
    endtask

    task automatic run_blink_session();
        time_t   t;
        time_t   per;
        secs_t   secs;
        int      n;
        int      pick;
        opcode_t op;
        t = $urandom;
        if ($urandom_range(0, 3) == 0)
            t = time_t'(0) - time_t'($urandom_range(1, 300000));
        per  = ($urandom_range(0, 3) == 0) ? time_t'($urandom) : time_t'($urandom_range(0, 2000));
        secs = ($urandom_range(0, 5) == 0) ? secs_t'($urandom) : secs_t'($urandom_range(0, 3));
        send_cmd(OP_START, t, secs, per);
        n = $urandom_range(3, 15);
        repeat (n)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                t = $urandom;
            else if (pick == 1)
                t = t - time_t'($urandom_range(0, 500));
            else if (per < 4000)
                t = t + time_t'($urandom_range(0, int'(per) * 2 + 10));
            else
                t = t + time_t'($urandom_range(0, 4000));
            pick = $urandom_range(0, 15);
            if (pick == 0)
                op = OP_STOP;
            else if (pick == 1)
                op = OP_START;
            else if (pick == 2)
                op = opcode_t'(3);
            else
                op = OP_UPDATE;
            send_cmd(op, t, secs_t'($urandom), $urandom);
        end
    endtask

    task automatic test_random_sessions();
        logic rest_plan [5];
        int   target;
        rest_plan[0] = 1'b0;
        rest_plan[1] = 1'b1;
        rest_plan[2] = logic'($urandom_range(0, 1));
        rest_plan[3] = 1'b1;
        rest_plan[4] = 1'b0;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_rest_level(rest_plan[phase]);
            target = items_sent + 130;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 3) == 0)
                    burst_mode = ~burst_mode;
                if ($urandom_range(0, 4) == 0)
                    send_cmd(opcode_t'($urandom_range(0, 3)), $urandom, secs_t'($urandom),
                             $urandom);
                else
                    run_blink_session();
            end
        end
        burst_mode = 1'b0;
    endtask

    // response sink with random stalls and one long hold-off on request
    initial
    begin : status_sink
        int gap;
        status_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                status_bus.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                gap = draw_gap();
                if (gap > 0)
                begin
                    status_bus.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            status_bus.ready <= 1'b1;
            @(posedge clk);
            while (!status_bus.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_bus.valid && status_bus.ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("unexpected status: led_lit %0b is_blinking %0b",
                       status_bus.data.led_lit, status_bus.data.is_blinking);
                mismatch_count++;
            end
            else
            begin
                if (expected_status[0].led_lit !== status_bus.data.led_lit)
                begin
                    $error("led_lit: expected %0b, actual %0b",
                           expected_status[0].led_lit, status_bus.data.led_lit);
                    mismatch_count++;
                end
                if (expected_status[0].is_blinking !== status_bus.data.is_blinking)
                begin
                    $error("is_blinking: expected %0b, actual %0b",
                           expected_status[0].is_blinking, status_bus.data.is_blinking);
                    mismatch_count++;
                end
                void'(expected_status.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (cmd_bus.valid && cmd_bus.ready) ||
            (status_bus.valid && status_bus.ready))
            stall_cycles = 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles++;
    end

    initial
    begin : main_seq
        cmd_bus.valid   <= 1'b0;
        cmd_bus.data    <= '0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        rst_n           <= 1'b0;
        sim_last_toggle = '0;
        sim_deadline    = DEADLINE_NONE;
        sim_period      = '0;
        sim_led         = 1'b0;
        sim_rest_on     = 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        stall_cycles    = 0;
        hold_request    = 0;
        burst_mode      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_rest_level();
        test_input_stall();
        test_random_sessions();

        wait_idle();
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
